// ===== design/itoa_pkg.sv =====
// Shared types, constants and helpers for the signed integer to ASCII converter.
package itoa_pkg;

  // Value width and field widths
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned RADIX_W    = 8;
  localparam int unsigned DIGIT_W    = 6;
  localparam int unsigned CHAR_W     = 8;

  // Radix limits and fixed characters
  localparam logic [RADIX_W-1:0] MIN_RADIX  = 8'd2;
  localparam logic [RADIX_W-1:0] MAX_RADIX  = 8'd36;
  localparam logic [CHAR_W-1:0]  MINUS_CHAR = 8'h2D;
  localparam logic [CHAR_W-1:0]  BAD_CHAR   = 8'h00;
  localparam logic [CHAR_W-1:0]  ZERO_CHAR  = 8'h30;
  localparam logic [CHAR_W-1:0]  ALPHA_CHAR = 8'h61;
  localparam logic [DIGIT_W-1:0] TEN_DIGIT  = 6'd10;

  // Divider: STEP_BITS restoring steps per cycle
  localparam int unsigned STEP_BITS  = 8;
  localparam int unsigned DIV_CYCLES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned PAD_BITS   = DIV_CYCLES * STEP_BITS;
  localparam int unsigned STEP_CNT_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
  localparam int unsigned DEPTH_W    = $clog2(VALUE_BITS + 1);

  // Job queue between front and back (depth a power of two, at least 2)
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] number;
    logic [RADIX_W-1:0]           radix;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              final_res;
    logic              bad_radix;
  } out_item_t;

  // Classified job handed from front to back
  typedef struct packed {
    logic                  bad;
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
    logic [DIGIT_W-1:0]    radix;
  } job_t;

  // Digit value 0..35 to its ASCII glyph
  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] g;
    if (d < TEN_DIGIT) begin
      g = ZERO_CHAR + CHAR_W'(d);
    end else begin
      g = ALPHA_CHAR + CHAR_W'(d - TEN_DIGIT);
    end
    return g;
  endfunction

endpackage

// ===== design/signed_int_to_ascii_radix.sv =====
// Top level: signed integer to ASCII text converter, radix 2 to 36.
//
//   channel   handshake        payload            direction
//   input     push / full      in_item_i          into block, one number+radix
//   result    pop / empty      out_item_o         out of block, one character
//
// Each digit is produced by the shared divider, which retires
// 8 quotient bits a cycle; the digits then drain at one character a cycle
// while the result is popped. Reset is asynchronous and empties all queues.
// A held result stalls only the drain; the front and job queue keep
// taking items until they are full.
module signed_int_to_ascii_radix (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  itoa_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output itoa_pkg::out_item_t out_item_o
);
  import itoa_pkg::*;

  logic fr_valid, fr_ready;
  job_t fr_job;
  logic bk_valid, bk_ready;
  job_t bk_job;
  logic res_valid;

  itoa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .job_valid_o (fr_valid),
    .job_ready_i (fr_ready),
    .job_o       (fr_job)
  );

  itoa_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_job_i   (fr_job),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_job_o   (bk_job)
  );

  itoa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (bk_valid),
    .job_ready_o (bk_ready),
    .job_i       (bk_job),
    .res_valid_o (res_valid),
    .res_pop_i   (pop),
    .res_o       (out_item_o)
  );

  assign empty = !res_valid;

  // A bad-radix item is always a lone final character of code zero
  a_bad_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.bad_radix) |->
      (out_item_o.final_res && out_item_o.character == BAD_CHAR))
    else $error("bad radix result not final or nonzero");

  // The minus sign never ends a run
  a_sign_not_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.character == MINUS_CHAR) |-> !out_item_o.final_res)
    else $error("minus sign marked as last character");

  // After a sign is taken, the next character shown is a digit, not another sign
  a_digit_after_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && out_item_o.character == MINUS_CHAR) ##1 !empty |->
      (out_item_o.character != MINUS_CHAR && !out_item_o.bad_radix))
    else $error("sign not followed by a digit");

endmodule

// ===== design/itoa_front.sv =====
// Front end: input register and classification of each item into a job.
module itoa_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  itoa_pkg::in_item_t in_item_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output itoa_pkg::job_t     job_o
);
  import itoa_pkg::*;

  logic     in_vld_q;
  in_item_t in_q;
  logic     accept;

  // One-entry input buffer; refills in the cycle it hands off
  assign full   = in_vld_q && !job_ready_i;
  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (job_ready_i) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_i;
    end
  end

  // Classify: radix range, sign, magnitude (minimum value maps to top bit)
  always_comb begin
    job_o.bad   = (in_q.radix < MIN_RADIX) || (in_q.radix > MAX_RADIX);
    job_o.neg   = in_q.number[VALUE_BITS-1];
    job_o.mag   = job_o.neg ? (VALUE_BITS'(0) - VALUE_BITS'(in_q.number))
                            : VALUE_BITS'(in_q.number);
    job_o.radix = in_q.radix[DIGIT_W-1:0];
  end

  assign job_valid_o = in_vld_q;

endmodule

// ===== design/itoa_queue.sv =====
// Short job queue decoupling the front end from the conversion engine.
module itoa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  itoa_pkg::job_t wr_job_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output itoa_pkg::job_t rd_job_o
);
  import itoa_pkg::*;

  job_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              wr_en, rd_en;

  assign wr_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_ready_i && rd_valid_o;
  assign rd_job_o   = slot_q[rptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_en) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (rd_en) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wptr_q] <= wr_job_i;
    end
  end

endmodule

// ===== design/itoa_back.sv =====
// Conversion engine: iterative divider, digit stack and output register.
module itoa_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  itoa_pkg::job_t      job_i,
  output logic                res_valid_o,
  input  logic                res_pop_i,
  output itoa_pkg::out_item_t res_o
);
  import itoa_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SIGN = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_BAD  = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [PAD_BITS-1:0]   work_q, work_d;
  logic [DIGIT_W-1:0]    rem_q, rem_d;
  logic [DIGIT_W-1:0]    radix_q, radix_d;
  logic                  neg_q, neg_d;
  logic [STEP_CNT_W-1:0] step_q, step_d;
  logic [DIGIT_W-1:0]    stack_q [VALUE_BITS];
  logic [DIGIT_W-1:0]    stack_d [VALUE_BITS];
  logic [DEPTH_W-1:0]    depth_q, depth_d;
  logic                  out_vld_q, out_vld_d;
  out_item_t             out_q, out_d;

  logic                  out_free;
  logic [PAD_BITS-1:0]   step_work;
  logic [DIGIT_W-1:0]    step_rem;
  logic                  last_step;

  assign out_free    = !out_vld_q || res_pop_i;
  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;
  assign job_ready_o = (state_q == S_IDLE);
  assign last_step   = (step_q == STEP_CNT_W'(DIV_CYCLES - 1));

  // STEP_BITS restoring division steps on the narrow remainder
  always_comb begin
    logic [DIGIT_W:0]    t;
    logic [DIGIT_W-1:0]  r;
    logic [PAD_BITS-1:0] w;
    logic                qb;
    r = rem_q;
    w = work_q;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {r, w[PAD_BITS-1]};
      if (t >= {1'b0, radix_q}) begin
        t  = t - {1'b0, radix_q};
        qb = 1'b1;
      end else begin
        qb = 1'b0;
      end
      r = t[DIGIT_W-1:0];
      w = {w[PAD_BITS-2:0], qb};
    end
    step_rem  = r;
    step_work = w;
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    work_d    = work_q;
    rem_d     = rem_q;
    radix_d   = radix_q;
    neg_d     = neg_q;
    step_d    = step_q;
    stack_d   = stack_q;
    depth_d   = depth_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !res_pop_i;

    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          work_d  = PAD_BITS'(job_i.mag);
          rem_d   = '0;
          radix_d = job_i.radix;
          neg_d   = job_i.neg;
          step_d  = '0;
          depth_d = '0;
          state_d = job_i.bad ? S_BAD : S_DIV;
        end
      end
      S_DIV: begin
        if (last_step) begin
          // digit done: push it, continue with the quotient
          stack_d[0] = step_rem;
          for (int i = 1; i < VALUE_BITS; i++) begin
            stack_d[i] = stack_q[i-1];
          end
          depth_d = depth_q + DEPTH_W'(1);
          work_d  = step_work;
          rem_d   = '0;
          step_d  = '0;
          if (step_work == '0) begin
            state_d = neg_q ? S_SIGN : S_EMIT;
          end
        end else begin
          work_d = step_work;
          rem_d  = step_rem;
          step_d = step_q + STEP_CNT_W'(1);
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = '{character: MINUS_CHAR, final_res: 1'b0, bad_radix: 1'b0};
          state_d   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = '{character: digit_glyph(stack_q[0]),
                        final_res: (depth_q == DEPTH_W'(1)), bad_radix: 1'b0};
          for (int i = 0; i < VALUE_BITS - 1; i++) begin
            stack_d[i] = stack_q[i+1];
          end
          stack_d[VALUE_BITS-1] = '0;
          depth_d = depth_q - DEPTH_W'(1);
          if (depth_q == DEPTH_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      S_BAD: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = '{character: BAD_CHAR, final_res: 1'b1, bad_radix: 1'b1};
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      depth_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      depth_q   <= depth_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    rem_q   <= rem_d;
    radix_q <= radix_d;
    neg_q   <= neg_d;
    stack_q <= stack_d;
    out_q   <= out_d;
  end

endmodule

// ===== tb/sv/signed_int_to_ascii_radix_test.sv =====
// Testbench for the signed integer to ASCII radix converter: queued stimulus, scoreboard checks.
module signed_int_to_ascii_radix_test;
  import itoa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam string DIGIT_GLYPHS   = "0123456789abcdefghijklmnopqrstuvwxyz";
  localparam int    RANDOM_PER_RUN = 100;
  localparam int    LONG_HOLD      = 2000;
  localparam int    DRAIN_CYCLES   = 200;
  localparam int    MAX_REPORTS    = 10;

  logic      clk_i      = 1'b0;
  logic      rst_ni     = 1'b0;
  logic      push       = 1'b0;
  logic      pop        = 1'b0;
  in_item_t  in_item_i  = '0;
  logic      full;
  logic      empty;
  out_item_t out_item_o;

  in_item_t  numbers_to_send [$];
  out_item_t expected_text [$];

  int  sender_idle_pct = 0;
  int  reader_idle_pct = 0;
  int  items_taken     = 0;
  int  offered_at      = 0;
  int  chars_checked   = 0;
  int  bad_radix_items = 0;
  int  error_count     = 0;
  int  hold_left       = 0;
  int  full_during_hold = 0;
  bit  want_long_hold  = 1'b0;
  bit  hold_started    = 1'b0;

  signed_int_to_ascii_radix i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Expected character run for one number, most significant first
  function automatic void expect_text(input in_item_t it);
    out_item_t             ch;
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] digit;
    logic [CHAR_W-1:0]     rev [VALUE_BITS];
    int                    n;
    bit                    neg;
    n = 0;
    if (it.radix < MIN_RADIX || it.radix > MAX_RADIX) begin
      ch.character = BAD_CHAR;
      ch.final_res = 1'b1;
      ch.bad_radix = 1'b1;
      expected_text.push_back(ch);
      bad_radix_items++;
      return;
    end
    neg = it.number[VALUE_BITS-1];
    // two's complement magnitude; the most negative value maps to 2^31 exactly
    mag = neg ? (~it.number + 1'b1) : it.number;
    do begin
      digit  = mag % it.radix;
      mag    = mag / it.radix;
      rev[n] = DIGIT_GLYPHS[int'(digit)];
      n++;
    end while (mag != '0);
    if (neg) begin
      ch.character = MINUS_CHAR;
      ch.final_res = 1'b0;
      ch.bad_radix = 1'b0;
      expected_text.push_back(ch);
    end
    for (int i = n - 1; i >= 0; i--) begin
      ch.character = rev[i];
      ch.final_res = (i == 0);
      ch.bad_radix = 1'b0;
      expected_text.push_back(ch);
    end
  endfunction

  function automatic void report_error(input string what, input out_item_t want,
                                       input out_item_t got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected char=%h last=%b bad=%b, got char=%h last=%b bad=%b",
               $realtime, what, want.character, want.final_res, want.bad_radix,
               got.character, got.final_res, got.bad_radix);
    end
  endfunction

  // Sample both handshakes at the rising edge: predict on accept, check on pop
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && push && !full) begin
      expect_text(in_item_i);
      void'(numbers_to_send.pop_front());
      items_taken <= items_taken + 1;
    end
    if (rst_ni && pop && !empty) begin
      if (expected_text.size() == 0) begin
        report_error("unexpected character", '0, out_item_o);
      end else begin
        want = expected_text.pop_front();
        chars_checked++;
        if (out_item_o.character != want.character ||
            out_item_o.final_res != want.final_res ||
            out_item_o.bad_radix != want.bad_radix) begin
          report_error("character mismatch", want, out_item_o);
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering items
  always @(posedge clk_i) begin
    if (want_long_hold && !hold_started) begin
      hold_left    <= LONG_HOLD;
      hold_started <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      if (full) full_during_hold <= full_during_hold + 1;
    end
  end

  // Sender: present the queue head, hold it until taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (push && items_taken == offered_at) begin
      push <= 1'b1;
    end else if (numbers_to_send.size() != 0 &&
                 $urandom_range(99) >= sender_idle_pct) begin
      push       <= 1'b1;
      in_item_i  <= numbers_to_send[0];
      offered_at <= items_taken;
    end else begin
      push <= 1'b0;
    end
  end

  // Receiver: random pop, off during the long hold
  always @(negedge clk_i) begin
    if (!rst_ni || hold_left != 0) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= reader_idle_pct);
    end
  end

  task automatic add_number(input logic signed [VALUE_BITS-1:0] num,
                            input logic [RADIX_W-1:0] radix);
    in_item_t it;
    it.number = num;
    it.radix  = radix;
    numbers_to_send.push_back(it);
  endtask

  // Random number shaped toward short runs, extremes and digit boundaries
  function automatic logic signed [VALUE_BITS-1:0] pick_number(input logic [RADIX_W-1:0] radix);
    logic [VALUE_BITS-1:0] p;
    int                    k;
    case ($urandom_range(9))
      0, 1, 2, 3: pick_number = $urandom;
      4, 5:       pick_number = $urandom_range(2000) - 1000;
      6: begin
        case ($urandom_range(3))
          0: pick_number = {1'b1, {(VALUE_BITS-1){1'b0}}};
          1: pick_number = {1'b0, {(VALUE_BITS-1){1'b1}}};
          2: pick_number = '0;
          default: pick_number = '1;
        endcase
      end
      7: begin
        // a power of the radix, nudged by one either way
        p = 1;
        k = $urandom_range(1, 31);
        while (k > 0 && radix >= MIN_RADIX && radix <= MAX_RADIX &&
               p <= ({1'b0, {(VALUE_BITS-1){1'b1}}} / radix)) begin
          p = p * radix;
          k--;
        end
        pick_number = p + $urandom_range(2) - 1;
        if ($urandom_range(1)) pick_number = -pick_number;
      end
      default: pick_number = $signed($urandom) >>> $urandom_range(31);
    endcase
  endfunction

  task automatic add_random(input int count);
    logic [RADIX_W-1:0] radix;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(19))
        0:       radix = RADIX_W'($urandom_range(1));
        1, 2:    radix = RADIX_W'($urandom_range(MAX_RADIX + 1, 255));
        default: radix = RADIX_W'($urandom_range(MIN_RADIX, MAX_RADIX));
      endcase
      add_number(pick_number(radix), radix);
    end
  endtask

  task automatic wait_idle();
    while (numbers_to_send.size() != 0 || push || expected_text.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Run limit
  initial begin
    #10ms;
    $display("signed_int_to_ascii_radix regression: fail");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Phase 1: directed corners, then random; sender rarely idle, receiver mostly idle
    sender_idle_pct = 8;
    reader_idle_pct = 81;
    add_number(0, 10);
    add_number(0, 2);
    add_number(1, 2);
    add_number(-1, 10);
    add_number(35, 36);
    add_number(-35, 36);
    add_number(32'sh7fffffff, 2);
    add_number(32'sh7fffffff, 36);
    add_number(32'sh80000000, 2);
    add_number(32'sh80000000, 10);
    add_number(32'sh80000000, 16);
    add_number(32'sh80000000, 36);
    add_number(32'sh80000001, 3);
    add_number(32'shdeadbeef, 16);
    add_number(1000000, 10);
    add_number(-255, 16);
    add_number(7, 8);
    add_number(12345, 0);
    add_number(99, 1);
    add_number(-5, 37);
    add_number(0, 255);
    add_number(42, 128);
    add_number(-36, 36);
    add_random(RANDOM_PER_RUN);
    wait_idle();

    // Phase 2: idling the other way round
    sender_idle_pct = 81;
    reader_idle_pct = 8;
    add_random(RANDOM_PER_RUN);
    wait_idle();

    // Phase 3: no idling, with one long receiver hold-off up front
    sender_idle_pct = 0;
    reader_idle_pct = 0;
    add_random(RANDOM_PER_RUN);
    want_long_hold = 1'b1;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Converted %0d numbers (%0d with a bad radix) into %0d checked characters.",
             items_taken, bad_radix_items, chars_checked);
    $display("Input stalled on full for %0d cycles of the long hold-off; %0d mismatches.",
             full_during_hold, error_count);
    if (error_count == 0 && expected_text.size() == 0) begin
      $display("signed_int_to_ascii_radix regression: pass");
    end else begin
      $display("signed_int_to_ascii_radix regression: fail");
    end
    $finish;
  end

endmodule
